// ===== rtl/bpewm_pkg.sv =====
// ----------------------------------------------------------------------------
// bpewm_pkg
// Shared types and constants of the byte-pair merge engine.
// ----------------------------------------------------------------------------
package bpewm_pkg;

    localparam int ID_W = 20;
    localparam logic [31:0] HASH_MUL_A = 32'h9e3779b1;
    localparam logic [31:0] HASH_MUL_B = 32'h85ebca6b;
    localparam logic [ID_W-1:0] VOCAB_RESET = 20'd1000000;
    localparam int BYTE_VALUES = 256;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_MAP    = 2'd1,
        CMD_PUSH   = 2'd2,
        CMD_END    = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_OK    = 3'd0,
        ST_DUP   = 3'd1,
        ST_FULL  = 3'd2,
        ST_OVF   = 3'd3,
        ST_RANGE = 3'd4
    } status_t;

    typedef enum logic {
        TBL_LOOKUP = 1'b0,
        TBL_INSERT = 1'b1
    } tbl_op_t;

    typedef struct packed {
        logic            valid;
        tbl_op_t         op;
        logic [ID_W-1:0] left_id;
        logic [ID_W-1:0] right_id;
        logic [ID_W-1:0] merged_id;
    } tbl_req_t;

    typedef struct packed {
        logic            hit;
        logic [ID_W-1:0] merged_id;
        status_t         status;
    } tbl_rsp_t;

    typedef struct packed {
        cmd_t            cmd;
        logic [ID_W-1:0] left_id;
        logic [ID_W-1:0] right_id;
        logic [ID_W-1:0] merged_id;
        logic [7:0]      byte_value;
        logic [ID_W-1:0] byte_token_id;
        logic            byte_token_valid;
    } bpewm_in_t;

    typedef struct packed {
        logic [ID_W-1:0] token_id;
        logic            token_valid;
        logic            last;
        status_t         status;
    } bpewm_out_t;

    typedef enum logic [1:0] {
        T_CLEAR,
        T_IDLE,
        T_HASH,
        T_CHECK
    } tbl_state_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INS_REQ,
        S_INS_WAIT,
        S_EMIT1,
        S_PUSH,
        S_M_START,
        S_M_RD0,
        S_M_RD1,
        S_M_LOOK,
        S_M_APPLY,
        S_SHIFT,
        S_OUT_START,
        S_OUT_EMIT
    } top_state_t;

endpackage

// ===== rtl/bpewm_pair_table.sv =====
// ----------------------------------------------------------------------------
// bpewm_pair_table
// Linear-probing hash table of merge rules with lookup and insert.
// ----------------------------------------------------------------------------
module bpewm_pair_table #(
    parameter int HASH_BITS = 16
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  bpewm_pkg::tbl_req_t     req,
    output logic                    ready,
    output logic                    done,
    output bpewm_pkg::tbl_rsp_t     rsp,
    output logic [HASH_BITS-1:0]    rank
);
    import bpewm_pkg::*;

    localparam int DEPTH = 1 << HASH_BITS;
    localparam int PROD_W = HASH_BITS + ID_W;
    localparam logic [HASH_BITS-1:0] MUL_A = HASH_MUL_A[HASH_BITS-1:0];
    localparam logic [HASH_BITS-1:0] MUL_B = HASH_MUL_B[HASH_BITS-1:0];

    typedef struct packed {
        logic                 used;
        logic [ID_W-1:0]      left_id;
        logic [ID_W-1:0]      right_id;
        logic [ID_W-1:0]      merged_id;
        logic [HASH_BITS-1:0] rank;
    } entry_t;

    entry_t mem [DEPTH];
    entry_t rd_data;

    tbl_state_t           state_reg, state_next;
    tbl_op_t              op_reg, op_next;
    logic [ID_W-1:0]      a_reg, a_next, b_reg, b_next, c_reg, c_next;
    logic [HASH_BITS-1:0] slot_reg, slot_next;
    logic [HASH_BITS-1:0] probes_reg, probes_next;
    logic [HASH_BITS-1:0] clr_reg, clr_next;
    logic [HASH_BITS-1:0] count_reg, count_next;
    logic                 done_reg, done_next;
    tbl_rsp_t             rsp_reg, rsp_next;
    logic [HASH_BITS-1:0] rank_reg, rank_next;

    logic                 rd_en, wr_en;
    logic [HASH_BITS-1:0] rd_addr, wr_addr;
    entry_t               wr_data;
    logic [PROD_W-1:0]    prod_a, prod_b;

    assign prod_a = PROD_W'(a_reg) * PROD_W'(MUL_A);
    assign prod_b = PROD_W'(b_reg) * PROD_W'(MUL_B);

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

    always_comb begin
        state_next  = state_reg;
        op_next     = op_reg;
        a_next      = a_reg;
        b_next      = b_reg;
        c_next      = c_reg;
        slot_next   = slot_reg;
        probes_next = probes_reg;
        clr_next    = clr_reg;
        count_next  = count_reg;
        done_next   = 1'b0;
        rsp_next    = rsp_reg;
        rank_next   = rank_reg;
        rd_en       = 1'b0;
        rd_addr     = slot_reg;
        wr_en       = 1'b0;
        wr_addr     = slot_reg;
        wr_data     = '{used: 1'b1, left_id: a_reg, right_id: b_reg,
                        merged_id: c_reg, rank: count_reg};
        case (state_reg)
            T_CLEAR: begin
                wr_en    = 1'b1;
                wr_addr  = clr_reg;
                wr_data  = '0;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == '1) begin
                    state_next = T_IDLE;
                end
            end
            T_IDLE: begin
                if (req.valid) begin
                    op_next    = req.op;
                    a_next     = req.left_id;
                    b_next     = req.right_id;
                    c_next     = req.merged_id;
                    state_next = T_HASH;
                end
            end
            T_HASH: begin
                // The first probe is read at the home slot of the pair.
                slot_next   = prod_a[HASH_BITS-1:0] ^ prod_b[HASH_BITS-1:0];
                probes_next = '0;
                rd_en       = 1'b1;
                rd_addr     = slot_next;
                state_next  = T_CHECK;
            end
            T_CHECK: begin
                if (!rd_data.used) begin
                    rsp_next = '{hit: 1'b0, merged_id: '0, status: ST_OK};
                    if (op_reg == TBL_INSERT) begin
                        wr_en      = 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                    done_next  = 1'b1;
                    state_next = T_IDLE;
                end else if (rd_data.left_id == a_reg && rd_data.right_id == b_reg) begin
                    rsp_next = '{hit: 1'b1, merged_id: rd_data.merged_id,
                                 status: (op_reg == TBL_INSERT) ? ST_DUP : ST_OK};
                    rank_next  = rd_data.rank;
                    done_next  = 1'b1;
                    state_next = T_IDLE;
                end else if (probes_reg == '1) begin
                    rsp_next = '{hit: 1'b0, merged_id: '0,
                                 status: (op_reg == TBL_INSERT) ? ST_FULL : ST_OK};
                    done_next  = 1'b1;
                    state_next = T_IDLE;
                end else begin
                    slot_next   = slot_reg + 1'b1;
                    probes_next = probes_reg + 1'b1;
                    rd_en       = 1'b1;
                    rd_addr     = slot_next;
                end
            end
            default: begin
                state_next = T_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg  <= T_CLEAR;
            op_reg     <= TBL_LOOKUP;
            a_reg      <= '0;
            b_reg      <= '0;
            c_reg      <= '0;
            slot_reg   <= '0;
            probes_reg <= '0;
            clr_reg    <= '0;
            count_reg  <= '0;
            done_reg   <= 1'b0;
            rsp_reg    <= '0;
            rank_reg   <= '0;
        end else begin
            state_reg  <= state_next;
            op_reg     <= op_next;
            a_reg      <= a_next;
            b_reg      <= b_next;
            c_reg      <= c_next;
            slot_reg   <= slot_next;
            probes_reg <= probes_next;
            clr_reg    <= clr_next;
            count_reg  <= count_next;
            done_reg   <= done_next;
            rsp_reg    <= rsp_next;
            rank_reg   <= rank_next;
        end
    end

    assign ready = (state_reg == T_IDLE);
    assign done  = done_reg;
    assign rsp   = rsp_reg;
    assign rank  = rank_reg;

    a_req_when_ready: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid |-> state_reg == T_IDLE)
        else $error("pair table request while busy");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> state_reg == T_IDLE)
        else $error("pair table done outside idle");

    a_rank_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == T_CHECK && wr_en) |=>
            count_reg == HASH_BITS'($past(count_reg) + 1'b1))
        else $error("rule count not advanced on insert");

endmodule

// ===== rtl/bpe_word_merge_engine_unit.sv =====
// ----------------------------------------------------------------------------
// bpe_word_merge_engine_unit
// Ranked byte-pair merging of one word with a hashed rule table.
// ----------------------------------------------------------------------------
// Insert checks the ids against the vocabulary size, then probes the rule table
// from the home slot of the pair; an id out of range skips the table. Insert and
// byte map each give one result item; push gives no result item. No new item
// enters before the engine is through with the current one.
// End of word runs passes of (len-1) lookups each, plus a shift of the tail per
// merge; tokens then leave one a cycle while the receiver does not stall.
// After reset a clearing pass empties the rule table, during which no item is
// accepted; configuration writes are taken always.
module bpe_word_merge_engine_unit #(
    parameter int HASH_BITS = 16,
    parameter int MAX_WORD  = 64
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   req_valid,
    output logic                   req_stall,
    input  bpewm_pkg::bpewm_in_t   req_item,
    output logic                   rsp_valid,
    input  logic                   rsp_stall,
    output bpewm_pkg::bpewm_out_t  rsp_item,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [19:0]            cfg_data
);
    import bpewm_pkg::*;

    localparam int LEN_W = $clog2(MAX_WORD + 1);
    localparam int IDX_W = $clog2(MAX_WORD);

    // The word buffer and the byte map data are synchronous memories; the
    // byte map validity lives in flip-flops so that reset clears it at once.
    logic [ID_W-1:0] word_mem [MAX_WORD];
    logic [ID_W-1:0] map_mem [BYTE_VALUES];
    logic [ID_W-1:0] word_rd_data, map_rd_data;

    logic             word_we, word_re, map_we, map_re;
    logic [IDX_W-1:0] word_waddr, word_raddr;
    logic [ID_W-1:0]  word_wdata;
    logic [7:0]       map_addr;

    top_state_t       state_reg, state_next;
    logic [ID_W-1:0]  vocab_reg, vocab_next;
    bpewm_in_t        item_reg, item_next;
    logic [BYTE_VALUES-1:0] map_valid_reg, map_valid_next;
    logic             push_valid_reg, push_valid_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic             ovf_reg, ovf_next;
    logic [LEN_W-1:0] idx_reg, idx_next;
    logic [ID_W-1:0]  prev_reg, prev_next, cur_reg, cur_next;
    logic             found_reg, found_next;
    logic [HASH_BITS-1:0] best_rank_reg, best_rank_next;
    logic [LEN_W-1:0] best_at_reg, best_at_next;
    logic [ID_W-1:0]  best_id_reg, best_id_next;
    status_t          res_reg, res_next;
    bpewm_out_t       out_reg, out_next;
    logic             out_valid_reg, out_load, out_free;

    tbl_req_t             tbl_req;
    tbl_rsp_t             tbl_rsp;
    logic                 tbl_ready, tbl_done;
    logic [HASH_BITS-1:0] tbl_rank;

    logic             accept;
    status_t          word_status;
    logic [LEN_W:0]   idx_plus2, best_plus2, len_ext;

    bpewm_pair_table #(
        .HASH_BITS(HASH_BITS)
    ) u_table (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (tbl_req),
        .ready (tbl_ready),
        .done  (tbl_done),
        .rsp   (tbl_rsp),
        .rank  (tbl_rank)
    );

    always_ff @(posedge clk) begin
        if (word_we) begin
            word_mem[word_waddr] <= word_wdata;
        end
        if (word_re) begin
            word_rd_data <= word_mem[word_raddr];
        end
        if (map_we) begin
            map_mem[map_addr] <= item_next.byte_token_id;
        end
        if (map_re) begin
            map_rd_data <= map_mem[map_addr];
        end
    end

    assign accept      = req_valid && (state_reg == S_IDLE) && tbl_ready;
    assign req_stall   = !((state_reg == S_IDLE) && tbl_ready);
    assign out_free    = !out_valid_reg || !rsp_stall;
    assign word_status = ovf_reg ? ST_OVF : ST_OK;
    assign idx_plus2   = {1'b0, idx_reg} + (LEN_W+1)'(2);
    assign best_plus2  = {1'b0, best_at_reg} + (LEN_W+1)'(2);
    assign len_ext     = {1'b0, len_reg};
    assign cfg_ready   = 1'b1;
    assign vocab_next  = cfg_valid ? cfg_data : vocab_reg;

    always_comb begin
        state_next      = state_reg;
        item_next       = item_reg;
        map_valid_next  = map_valid_reg;
        push_valid_next = push_valid_reg;
        len_next        = len_reg;
        ovf_next        = ovf_reg;
        idx_next        = idx_reg;
        prev_next       = prev_reg;
        cur_next        = cur_reg;
        found_next      = found_reg;
        best_rank_next  = best_rank_reg;
        best_at_next    = best_at_reg;
        best_id_next    = best_id_reg;
        res_next        = res_reg;
        out_next        = out_reg;
        out_load        = 1'b0;
        word_we         = 1'b0;
        word_waddr      = idx_reg[IDX_W-1:0];
        word_wdata      = word_rd_data;
        word_re         = 1'b0;
        word_raddr      = '0;
        map_we          = 1'b0;
        map_re          = 1'b0;
        map_addr        = req_item.byte_value;
        tbl_req         = '{valid: 1'b0, op: TBL_LOOKUP, left_id: prev_reg,
                            right_id: word_rd_data, merged_id: '0};

        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    item_next = req_item;
                    case (req_item.cmd)
                        CMD_INSERT: begin
                            // Range is checked before the table is touched.
                            if (req_item.left_id >= vocab_reg ||
                                req_item.right_id >= vocab_reg ||
                                req_item.merged_id >= vocab_reg) begin
                                res_next   = ST_RANGE;
                                state_next = S_EMIT1;
                            end else begin
                                state_next = S_INS_REQ;
                            end
                        end
                        CMD_MAP: begin
                            map_we = 1'b1;
                            map_valid_next[req_item.byte_value] = req_item.byte_token_valid;
                            res_next   = ST_OK;
                            state_next = S_EMIT1;
                        end
                        CMD_PUSH: begin
                            map_re          = 1'b1;
                            push_valid_next = map_valid_reg[req_item.byte_value];
                            state_next      = S_PUSH;
                        end
                        CMD_END: begin
                            state_next = S_M_START;
                        end
                        default: begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_INS_REQ: begin
                tbl_req = '{valid: 1'b1, op: TBL_INSERT, left_id: item_reg.left_id,
                            right_id: item_reg.right_id, merged_id: item_reg.merged_id};
                state_next = S_INS_WAIT;
            end
            S_INS_WAIT: begin
                if (tbl_done) begin
                    res_next   = tbl_rsp.status;
                    state_next = S_EMIT1;
                end
            end
            S_EMIT1: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    out_next   = '{token_id: '0, token_valid: 1'b0, last: 1'b1,
                                   status: res_reg};
                    state_next = S_IDLE;
                end
            end
            S_PUSH: begin
                if (push_valid_reg) begin
                    if (len_reg < LEN_W'(MAX_WORD)) begin
                        word_we    = 1'b1;
                        word_waddr = len_reg[IDX_W-1:0];
                        word_wdata = map_rd_data;
                        len_next   = len_reg + 1'b1;
                    end else begin
                        ovf_next = 1'b1;
                    end
                end
                state_next = S_IDLE;
            end
            S_M_START: begin
                // Each pass scans all adjacent pairs for the lowest rank.
                if (len_reg > LEN_W'(1)) begin
                    word_re    = 1'b1;
                    word_raddr = '0;
                    idx_next   = '0;
                    found_next = 1'b0;
                    state_next = S_M_RD0;
                end else begin
                    state_next = S_OUT_START;
                end
            end
            S_M_RD0: begin
                prev_next  = word_rd_data;
                word_re    = 1'b1;
                word_raddr = IDX_W'(1);
                state_next = S_M_RD1;
            end
            S_M_RD1: begin
                cur_next      = word_rd_data;
                tbl_req.valid = 1'b1;
                state_next    = S_M_LOOK;
            end
            S_M_LOOK: begin
                if (tbl_done) begin
                    if (tbl_rsp.hit && (!found_reg || tbl_rank < best_rank_reg)) begin
                        found_next     = 1'b1;
                        best_rank_next = tbl_rank;
                        best_at_next   = idx_reg;
                        best_id_next   = tbl_rsp.merged_id;
                    end
                    prev_next = cur_reg;
                    if (idx_plus2 < len_ext) begin
                        idx_next   = idx_reg + 1'b1;
                        word_re    = 1'b1;
                        word_raddr = idx_plus2[IDX_W-1:0];
                        state_next = S_M_RD1;
                    end else begin
                        state_next = S_M_APPLY;
                    end
                end
            end
            S_M_APPLY: begin
                if (!found_reg) begin
                    state_next = S_OUT_START;
                end else begin
                    word_we    = 1'b1;
                    word_waddr = best_at_reg[IDX_W-1:0];
                    word_wdata = best_id_reg;
                    idx_next   = best_at_reg + 1'b1;
                    if (best_plus2 < len_ext) begin
                        word_re    = 1'b1;
                        word_raddr = best_plus2[IDX_W-1:0];
                        state_next = S_SHIFT;
                    end else begin
                        len_next   = len_reg - 1'b1;
                        state_next = S_M_START;
                    end
                end
            end
            S_SHIFT: begin
                // Close the gap: token idx+1 moves down to idx.
                word_we    = 1'b1;
                word_waddr = idx_reg[IDX_W-1:0];
                word_wdata = word_rd_data;
                if (idx_plus2 < len_ext) begin
                    idx_next   = idx_reg + 1'b1;
                    word_re    = 1'b1;
                    word_raddr = idx_plus2[IDX_W-1:0];
                end else begin
                    len_next   = len_reg - 1'b1;
                    state_next = S_M_START;
                end
            end
            S_OUT_START: begin
                if (len_reg == '0) begin
                    if (out_free) begin
                        out_load   = 1'b1;
                        out_next   = '{token_id: '0, token_valid: 1'b0, last: 1'b1,
                                       status: word_status};
                        ovf_next   = 1'b0;
                        state_next = S_IDLE;
                    end
                end else begin
                    word_re    = 1'b1;
                    word_raddr = '0;
                    idx_next   = '0;
                    state_next = S_OUT_EMIT;
                end
            end
            S_OUT_EMIT: begin
                if (out_free) begin
                    out_load = 1'b1;
                    out_next = '{token_id: word_rd_data, token_valid: 1'b1,
                                 last: (idx_reg + 1'b1 == len_reg), status: word_status};
                    if (idx_reg + 1'b1 == len_reg) begin
                        len_next   = '0;
                        ovf_next   = 1'b0;
                        state_next = S_IDLE;
                    end else begin
                        idx_next   = idx_reg + 1'b1;
                        word_re    = 1'b1;
                        word_raddr = idx_next[IDX_W-1:0];
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg      <= S_IDLE;
            vocab_reg      <= VOCAB_RESET;
            item_reg       <= '0;
            map_valid_reg  <= '0;
            push_valid_reg <= 1'b0;
            len_reg        <= '0;
            ovf_reg        <= 1'b0;
            idx_reg        <= '0;
            prev_reg       <= '0;
            cur_reg        <= '0;
            found_reg      <= 1'b0;
            best_rank_reg  <= '0;
            best_at_reg    <= '0;
            best_id_reg    <= '0;
            res_reg        <= ST_OK;
            out_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            vocab_reg      <= vocab_next;
            item_reg       <= item_next;
            map_valid_reg  <= map_valid_next;
            push_valid_reg <= push_valid_next;
            len_reg        <= len_next;
            ovf_reg        <= ovf_next;
            idx_reg        <= idx_next;
            prev_reg       <= prev_next;
            cur_reg        <= cur_next;
            found_reg      <= found_next;
            best_rank_reg  <= best_rank_next;
            best_at_reg    <= best_at_next;
            best_id_reg    <= best_id_next;
            res_reg        <= res_next;
            if (out_load) begin
                out_reg <= out_next;
            end
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (!rsp_stall) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp_item  = out_reg;

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_item)))
        else $error("result item changed while stalled");

    a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> req_stall)
        else $error("input not stalled while busy");

    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= LEN_W'(MAX_WORD))
        else $error("word length above buffer size");

endmodule

// ===== tb/sv/tb_bpe_word_merge_engine_unit.sv =====
// ----------------------------------------------------------------------------
// tb_bpe_word_merge_engine_unit
// Self-checking testbench of the byte-pair merge engine. A scoreboard keeps
// its own copy of the rule table, byte map and word buffer, predicts the
// result items of every accepted command and checks them in order, under
// random idling on both sides, a long receiver hold-off and several
// vocabulary settings.
// ----------------------------------------------------------------------------
module tb_bpe_word_merge_engine_unit;

    timeunit 1ns;
    timeprecision 1ps;

    import bpewm_pkg::*;

    localparam int HASH_BITS = 16;
    localparam int MAX_WORD  = 64;
    localparam int TBL_SIZE  = 1 << HASH_BITS;
    localparam int LONG_HOLD = 3000;

    // The scoreboard mirrors the engine state and holds the queue of
    // token items still owed by the engine, oldest first.
    class merge_scoreboard;
        logic [20:0]     byte_map [BYTE_VALUES];
        bit              slot_used [TBL_SIZE];
        logic [ID_W-1:0] slot_left [TBL_SIZE];
        logic [ID_W-1:0] slot_right [TBL_SIZE];
        logic [ID_W-1:0] slot_merged [TBL_SIZE];
        int unsigned     slot_rank [TBL_SIZE];
        int unsigned     rule_total;
        logic [ID_W-1:0] word [$];
        bit              word_ovf;
        logic [ID_W-1:0] vocab;
        bpewm_out_t      owed_tokens [$];
        int              mismatches;

        function new();
            foreach (byte_map[i]) byte_map[i] = '0;
            foreach (slot_used[i]) slot_used[i] = 1'b0;
            rule_total = 0;
            word_ovf   = 1'b0;
            vocab      = VOCAB_RESET;
            mismatches = 0;
        endfunction

        function logic [HASH_BITS-1:0] slot_of(logic [ID_W-1:0] a, logic [ID_W-1:0] b);
            logic [31:0] h;
            h = (32'(a) * HASH_MUL_A) ^ (32'(b) * HASH_MUL_B);
            return h[HASH_BITS-1:0];
        endfunction

        // Returns the slot holding the pair, or -1 when absent.
        function int find_slot(logic [ID_W-1:0] a, logic [ID_W-1:0] b);
            logic [HASH_BITS-1:0] h;
            h = slot_of(a, b);
            for (int p = 0; p < TBL_SIZE; p++)
            begin
                if (!slot_used[h])
                    return -1;
                if (slot_left[h] == a && slot_right[h] == b)
                    return int'(h);
                h = h + 1'b1;
            end
            return -1;
        endfunction

        function status_t add_rule(logic [ID_W-1:0] a, logic [ID_W-1:0] b,
                                   logic [ID_W-1:0] c);
            logic [HASH_BITS-1:0] h;
            if (a >= vocab || b >= vocab || c >= vocab)
                return ST_RANGE;
            h = slot_of(a, b);
            for (int p = 0; p < TBL_SIZE; p++)
            begin
                if (!slot_used[h])
                begin
                    slot_used[h]   = 1'b1;
                    slot_left[h]   = a;
                    slot_right[h]  = b;
                    slot_merged[h] = c;
                    slot_rank[h]   = rule_total;
                    rule_total++;
                    return ST_OK;
                end
                if (slot_left[h] == a && slot_right[h] == b)
                    return ST_DUP;
                h = h + 1'b1;
            end
            return ST_FULL;
        endfunction

        // Lowest rank wins; the strict compare keeps the leftmost on ties.
        function void merge_word();
            int          s, best_at;
            int unsigned best_rank;
            logic [ID_W-1:0] best_id;
            bit          found;
            while (word.size() > 1)
            begin
                found     = 1'b0;
                best_rank = 32'hFFFF_FFFF;
                best_at   = 0;
                best_id   = '0;
                for (int i = 0; i + 1 < word.size(); i++)
                begin
                    s = find_slot(word[i], word[i+1]);
                    if (s >= 0 && slot_rank[s] < best_rank)
                    begin
                        best_rank = slot_rank[s];
                        best_at   = i;
                        best_id   = slot_merged[s];
                        found     = 1'b1;
                    end
                end
                if (!found)
                    break;
                word[best_at] = best_id;
                word.delete(best_at + 1);
            end
        endfunction

        function void owe(logic [ID_W-1:0] id, logic v, logic l, status_t st);
            bpewm_out_t r;
            r.token_id    = id;
            r.token_valid = v;
            r.last        = l;
            r.status      = st;
            owed_tokens.push_back(r);
        endfunction

        function void note_input(bpewm_in_t it);
            status_t st;
            case (it.cmd)
                CMD_INSERT: owe('0, 1'b0, 1'b1, add_rule(it.left_id, it.right_id, it.merged_id));
                CMD_MAP:
                begin
                    byte_map[it.byte_value] = it.byte_token_valid ?
                                              {1'b1, it.byte_token_id} : 21'd0;
                    owe('0, 1'b0, 1'b1, ST_OK);
                end
                CMD_PUSH:
                begin
                    if (byte_map[it.byte_value][20])
                    begin
                        if (word.size() < MAX_WORD)
                            word.push_back(byte_map[it.byte_value][ID_W-1:0]);
                        else
                            word_ovf = 1'b1;
                    end
                end
                default:
                begin
                    st = word_ovf ? ST_OVF : ST_OK;
                    merge_word();
                    if (word.size() == 0)
                        owe('0, 1'b0, 1'b1, st);
                    foreach (word[i])
                        owe(word[i], 1'b1, (i == word.size() - 1), st);
                    word.delete();
                    word_ovf = 1'b0;
                end
            endcase
        endfunction

        function void report(string what, bpewm_out_t exp_r, bpewm_out_t got);
            mismatches++;
            if (mismatches <= 10)
                $display({"%0t mismatch (%s): expected id=%0d v=%0b last=%0b st=%0d,",
                          " got id=%0d v=%0b last=%0b st=%0d"},
                         $realtime, what, exp_r.token_id, exp_r.token_valid, exp_r.last,
                         exp_r.status, got.token_id, got.token_valid, got.last, got.status);
        endfunction

        function void check_result(bpewm_out_t got);
            bpewm_out_t exp_r;
            if (owed_tokens.size() == 0)
            begin
                report("unexpected item", '0, got);
                return;
            end
            exp_r = owed_tokens.pop_front();
            if (got.token_id !== exp_r.token_id)
                report("token_id", exp_r, got);
            else if (got.token_valid !== exp_r.token_valid)
                report("token_valid", exp_r, got);
            else if (got.last !== exp_r.last)
                report("last", exp_r, got);
            else if (got.status !== exp_r.status)
                report("status", exp_r, got);
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        req_valid = 1'b0;
    logic        req_stall;
    bpewm_in_t   req_item = '0;
    logic        rsp_valid;
    logic        rsp_stall = 1'b1;
    bpewm_out_t  rsp_item;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [19:0] cfg_data = '0;

    merge_scoreboard tokens_sb = new();
    bit          long_hold_req = 1'b0;
    bit          calm = 1'b0;
    int          items_sent = 0;

    bpe_word_merge_engine_unit #(
        .HASH_BITS (HASH_BITS),
        .MAX_WORD  (MAX_WORD)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_item  (req_item),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_item  (rsp_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Idle draw: zero whenever the calm phase runs and in a quarter of other draws, else random.
    function automatic int idle_cycles();
        if (calm || $urandom_range(0, 3) == 0)
            return 0;
        return $urandom_range(0, 14);
    endfunction

    // Offers one item after an optional gap and waits until it is accepted.
    // Valid stays high when the next item follows with no gap, so it is
    // never dropped and raised within the same step.
    task automatic send_item(bpewm_in_t it, int gap);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_item  <= it;
        do @(posedge clk); while (req_stall);
        tokens_sb.note_input(it);
        items_sent++;
    endtask

    // Builds an item with every field random, then sets the ones that matter.
    function automatic bpewm_in_t noise_item(cmd_t c);
        bpewm_in_t it;
        it.cmd              = c;
        it.left_id          = ID_W'($urandom_range(0, 999999));
        it.right_id         = ID_W'($urandom_range(0, 999999));
        it.merged_id        = ID_W'($urandom_range(0, 999999));
        it.byte_value       = 8'($urandom_range(0, 255));
        it.byte_token_id    = ID_W'($urandom_range(0, 999999));
        it.byte_token_valid = 1'($urandom_range(0, 1));
        return it;
    endfunction

    task automatic do_insert(logic [ID_W-1:0] a, logic [ID_W-1:0] b, logic [ID_W-1:0] c);
        bpewm_in_t it;
        it = noise_item(CMD_INSERT);
        it.left_id   = a;
        it.right_id  = b;
        it.merged_id = c;
        send_item(it, idle_cycles());
    endtask

    task automatic do_map(logic [7:0] bv, logic [ID_W-1:0] id, logic v);
        bpewm_in_t it;
        it = noise_item(CMD_MAP);
        it.byte_value       = bv;
        it.byte_token_id    = id;
        it.byte_token_valid = v;
        send_item(it, idle_cycles());
    endtask

    task automatic do_push(logic [7:0] bv);
        bpewm_in_t it;
        it = noise_item(CMD_PUSH);
        it.byte_value = bv;
        send_item(it, idle_cycles());
    endtask

    task automatic do_end();
        send_item(noise_item(CMD_END), idle_cycles());
    endtask

    // Pushes give no item back, so after the last owed item the engine may
    // still be busy; a margin covers a push before the register write.
    task automatic write_vocab(logic [19:0] v);
        req_valid <= 1'b0;
        while (tokens_sb.owed_tokens.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        tokens_sb.vocab = v;
    endtask

    // Random phase: short words over a small alphabet so that rules hit,
    // with some noise commands mixed in.
    task automatic random_phase(int n_items, logic [19:0] vocab_now);
        int unsigned pick;
        logic [ID_W-1:0] id_cap;
        id_cap = (vocab_now > 20'd64) ? 20'd64 : vocab_now;
        repeat (n_items)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 15)
            begin
                if ($urandom_range(0, 7) == 0)
                    do_insert(ID_W'($urandom_range(0, 999999)),
                              ID_W'($urandom_range(0, 999999)),
                              ID_W'($urandom_range(0, 999999)));
                else
                    do_insert(ID_W'($urandom_range(0, id_cap - 1)),
                              ID_W'($urandom_range(0, id_cap - 1)),
                              ID_W'($urandom_range(0, id_cap - 1)));
            end
            else if (pick < 25)
            begin
                if ($urandom_range(0, 5) == 0)
                    do_map(8'($urandom_range(0, 255)), ID_W'($urandom_range(0, 999999)),
                           1'($urandom_range(0, 1)));
                else
                    do_map(8'($urandom_range(0, 15)), ID_W'($urandom_range(0, id_cap - 1)),
                           $urandom_range(0, 7) != 0);
            end
            else if (pick < 85)
                do_push(($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255)) :
                        8'($urandom_range(0, 15)));
            else
                do_end();
        end
        do_end();
    endtask

    // The receiver idles before each item and, on request, holds off for a
    // long stretch so that the engine fills up and stalls its input.
    initial
    begin : receiver
        int n;
        forever
        begin
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                n = LONG_HOLD;
            end
            else
                n = idle_cycles();
            if (n > 0)
            begin
                rsp_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            rsp_stall <= 1'b0;
            do @(posedge clk); while (!(rsp_valid && !rsp_stall));
            tokens_sb.check_result(rsp_item);
        end
    end

    initial
    begin : stimulus
        int wait_cycles;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part. The byte map covers the extreme ids and bytes.
        write_vocab(20'd1000000);
        do_map(8'd0, 20'd10, 1'b1);
        do_map(8'd255, 20'd999999, 1'b1);
        do_map(8'd1, 20'd0, 1'b1);
        do_map(8'd2, 20'd11, 1'b1);
        do_map(8'd3, 20'd12, 1'b0);
        do_insert(20'd10, 20'd10, 20'd20);
        do_insert(20'd10, 20'd10, 20'd21);
        do_insert(20'd0, 20'd999999, 20'd30);
        do_insert(20'd1000000, 20'd1, 20'd2);
        do_insert(20'd20, 20'd10, 20'd40);
        // Three equal tokens tie on one rule; the leftmost pair must win.
        do_push(8'd0);
        do_push(8'd0);
        do_push(8'd0);
        do_push(8'd3);
        do_end();
        do_push(8'd1);
        do_push(8'd255);
        do_push(8'd2);
        do_end();
        // Empty word, then a word running past the buffer.
        do_end();
        for (int i = 0; i < MAX_WORD + 3; i++)
            do_push(8'd2);
        do_end();

        // Narrowest vocabulary: ids at the bound are rejected.
        write_vocab(20'd256);
        do_insert(20'd255, 20'd255, 20'd255);
        do_insert(20'd256, 20'd0, 20'd0);
        do_insert(20'd0, 20'd0, 20'd256);
        random_phase(80, 20'd256);

        // Pressure: the receiver stops while the sender keeps offering.
        write_vocab(20'($urandom_range(257, 999999)));
        calm = 1'b1;
        long_hold_req = 1'b1;
        for (int i = 0; i < 40; i++)
            do_map(i[7:0], ID_W'($urandom_range(0, 63)), 1'b1);
        random_phase(50, tokens_sb.vocab);
        calm = 1'b0;
        random_phase(30, tokens_sb.vocab);

        write_vocab(20'd1000000);
        random_phase(80, 20'd1000000);

        req_valid <= 1'b0;
        wait_cycles = 0;
        while (tokens_sb.owed_tokens.size() != 0 && wait_cycles < 200000)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (200) @(posedge clk);
        if (tokens_sb.mismatches == 0 && tokens_sb.owed_tokens.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // This bound is far above any correct run, the clearing pass included.
    initial
    begin : watchdog
        #50ms;
        $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/bpewm_pkg.sv
rtl/bpewm_pair_table.sv
rtl/bpe_word_merge_engine_unit.sv
tb/sv/tb_bpe_word_merge_engine_unit.sv
